// File: rtl/core/usbdcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdcm_pkg
// Shared types, class mask bits and class mapping for the descriptor class
// mask unit.
// ----------------------------------------------------------------------------
package usbdcm_pkg;

   typedef enum logic [1:0] {
      OP_BEGIN_DEVICE = 2'd0,
      OP_BEGIN_CONFIG = 2'd1,
      OP_DESC_BYTE    = 2'd2,
      OP_END_DEVICE   = 2'd3
   } op_type;

   localparam logic [31:0] BIT_AUDIO   = 32'h0000_0002;
   localparam logic [31:0] BIT_COMM    = 32'h0000_0004;
   localparam logic [31:0] BIT_HID     = 32'h0000_0008;
   localparam logic [31:0] BIT_PRINTER = 32'h0000_0080;
   localparam logic [31:0] BIT_STORAGE = 32'h0000_0100;
   localparam logic [31:0] BIT_HUB     = 32'h0000_0200;
   localparam logic [31:0] BIT_VIDEO   = 32'h0000_4000;
   localparam logic [31:0] BIT_OTHER   = 32'h8000_0000;

   localparam logic [7:0] INTF_TYPE    = 8'd4;
   localparam logic [15:0] CLASS_OFFSET = 16'd5;
   localparam logic [7:0] INTF_MIN_LEN = 8'd6;

   // class byte found in an interface descriptor
   typedef struct packed {
      logic       hit;
      logic [7:0] class_code;
   } walk_hit_type;

   function automatic logic [31:0] class_bits(input logic [7:0] code);
      logic [31:0] bits;
      unique case (code)
         8'h01: bits = BIT_AUDIO;
         8'h02, 8'h0A, 8'hE0: bits = BIT_COMM;
         8'h03: bits = BIT_HID;
         8'h07: bits = BIT_PRINTER;
         8'h08: bits = BIT_STORAGE;
         8'h09: bits = BIT_HUB;
         8'h0E: bits = BIT_VIDEO;
         8'h10: bits = BIT_VIDEO | BIT_AUDIO;
         default: bits = BIT_OTHER;
      endcase
      return bits;
   endfunction

   function automatic logic [31:0] reduce_mask(input logic [31:0] m);
      logic [31:0] r;
      priority if ((m & BIT_PRINTER) != 32'd0) begin
         r = BIT_PRINTER;
      end else if ((m & BIT_COMM) != 32'd0) begin
         r = BIT_COMM;
      end else if ((m & (BIT_AUDIO | BIT_VIDEO)) != 32'd0) begin
         r = m & (BIT_AUDIO | BIT_VIDEO);
      end else begin
         r = m;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/usbdcm_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdcm_walker
// Descriptor walk state: tracks byte position and descriptor headers inside
// one configuration and flags interface class bytes.
// ----------------------------------------------------------------------------
module usbdcm_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  usbdcm_pkg::op_type    op,
   input  logic [7:0]            data_byte,
   input  logic [15:0]           total_length,
   output usbdcm_pkg::walk_hit_type hit
);
   import usbdcm_pkg::*;

   logic [15:0] config_total_ff, config_total_in;
   logic [15:0] byte_position_ff, byte_position_in;
   logic [15:0] next_header_ff, next_header_in;
   logic [7:0]  desc_length_ff, desc_length_in;
   logic [7:0]  desc_type_ff, desc_type_in;
   logic        walk_stopped_ff, walk_stopped_in;

   logic [15:0] rel;
   logic        hdr_fits;
   logic        body_fits;
   logic        pos_hdr_fits;
   logic        desc_last;

   assign rel          = byte_position_ff - next_header_ff;
   assign hdr_fits     = ({1'b0, next_header_ff} + 17'd2) <= {1'b0, config_total_ff};
   assign body_fits    = ({1'b0, next_header_ff} + {9'd0, desc_length_ff})
                         <= {1'b0, config_total_ff};
   assign pos_hdr_fits = ({1'b0, byte_position_ff} + 17'd2) <= {1'b0, config_total_ff};
   assign desc_last    = ({1'b0, rel} + 17'd1) == {9'd0, desc_length_ff};

   always_comb begin
      config_total_in  = config_total_ff;
      byte_position_in = byte_position_ff;
      next_header_in   = next_header_ff;
      desc_length_in   = desc_length_ff;
      desc_type_in     = desc_type_ff;
      walk_stopped_in  = walk_stopped_ff;
      hit.hit          = 1'b0;
      hit.class_code   = data_byte;
      if (step) begin
         unique case (op)
            OP_BEGIN_DEVICE, OP_END_DEVICE: begin
               walk_stopped_in = 1'b1;
            end
            OP_BEGIN_CONFIG: begin
               config_total_in  = total_length;
               byte_position_in = 16'd0;
               next_header_in   = 16'd0;
               desc_length_in   = 8'd0;
               desc_type_in     = 8'd0;
               walk_stopped_in  = 1'b0;
            end
            OP_DESC_BYTE: begin
               if (!walk_stopped_ff) begin
                  byte_position_in = byte_position_ff + 16'd1;
                  if (rel == 16'd0) begin
                     if (!hdr_fits) begin
                        walk_stopped_in = 1'b1;
                     end else begin
                        desc_length_in = data_byte;
                     end
                  end else if (rel == 16'd1 &&
                               (desc_length_ff == 8'd0 || !body_fits)) begin
                     desc_type_in    = data_byte;
                     walk_stopped_in = 1'b1;
                  end else if (rel == 16'd1 && desc_length_ff == 8'd1) begin
                     // one-byte descriptor: its type byte is the next bLength
                     desc_type_in   = data_byte;
                     next_header_in = byte_position_ff;
                     if (!pos_hdr_fits) begin
                        walk_stopped_in = 1'b1;
                     end else begin
                        desc_length_in = data_byte;
                     end
                  end else begin
                     if (rel == 16'd1) begin
                        desc_type_in = data_byte;
                     end
                     if (rel == CLASS_OFFSET && desc_type_ff == INTF_TYPE &&
                         desc_length_ff >= INTF_MIN_LEN) begin
                        hit.hit = 1'b1;
                     end
                     if (desc_last) begin
                        next_header_in = byte_position_ff + 16'd1;
                     end
                  end
               end
            end
            default: begin
               walk_stopped_in = walk_stopped_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         config_total_ff  <= 16'd0;
         byte_position_ff <= 16'd0;
         next_header_ff   <= 16'd0;
         desc_length_ff   <= 8'd0;
         desc_type_ff     <= 8'd0;
         walk_stopped_ff  <= 1'b1;
      end else begin
         config_total_ff  <= config_total_in;
         byte_position_ff <= byte_position_in;
         next_header_ff   <= next_header_in;
         desc_length_ff   <= desc_length_in;
         desc_type_ff     <= desc_type_in;
         walk_stopped_ff  <= walk_stopped_in;
      end
   end

endmodule

// File: rtl/core/usb_descriptor_class_mask_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_descriptor_class_mask_unit
// Walks configuration descriptor bytes and reports a reduced device class mask.
// ----------------------------------------------------------------------------
// One word is taken every clock cycle while the input side is not held. Each word is
// held in an input register and processed from there by the descriptor walk and
// the mask update; an end-device word puts the reduced class mask into the result
// register once that register is free. Only an end-device word waiting behind
// a stalled result holds the input side.
module usb_descriptor_class_mask_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_total_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_class_mask
);
   import usbdcm_pkg::*;

   logic        s1_valid_ff, s1_valid_in;
   op_type      s1_op_ff, s1_op_in;
   logic [7:0]  s1_byte_ff, s1_byte_in;
   logic [15:0] s1_total_ff, s1_total_in;
   logic [31:0] accum_mask_ff, accum_mask_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_mask_ff, rsp_mask_in;

   logic         out_free;
   logic         s1_fire;
   logic [31:0]  reduced;
   walk_hit_type hit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (s1_op_ff != OP_END_DEVICE || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign reduced   = reduce_mask(accum_mask_ff);

   usbdcm_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .step         (s1_fire),
      .op           (s1_op_ff),
      .data_byte    (s1_byte_ff),
      .total_length (s1_total_ff),
      .hit          (hit)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_byte_in  = s1_byte_ff;
      s1_total_in = s1_total_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_op_in    = op_type'(req_opcode);
         s1_byte_in  = req_data_byte;
         s1_total_in = req_total_length;
      end

      accum_mask_in = accum_mask_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (s1_fire) begin
         unique case (s1_op_ff)
            OP_BEGIN_DEVICE: begin
               accum_mask_in = (s1_byte_ff != 8'd0) ? class_bits(s1_byte_ff) : 32'd0;
            end
            OP_DESC_BYTE: begin
               if (hit.hit) begin
                  accum_mask_in = accum_mask_ff | class_bits(hit.class_code);
               end
            end
            OP_END_DEVICE: begin
               accum_mask_in = reduced;
               rsp_mask_in   = reduced;
               rsp_valid_in  = 1'b1;
            end
            default: begin
               accum_mask_in = accum_mask_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         accum_mask_ff <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         accum_mask_ff <= accum_mask_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_op_ff    <= s1_op_in;
      s1_byte_ff  <= s1_byte_in;
      s1_total_ff <= s1_total_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_mask = rsp_mask_ff;

endmodule

// File: rtl/core/usbdcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbdcm_checker
// Port-level checks on the result channel of the class mask unit.
// ----------------------------------------------------------------------------
module usbdcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_class_mask
);
   import usbdcm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_class_mask))
      else $error("result word changed while stalled");

   a_printer_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_class_mask & BIT_PRINTER) != 32'd0
         |-> rsp_class_mask == BIT_PRINTER)
      else $error("printer class not reported alone");

   a_comm_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_class_mask & BIT_COMM) != 32'd0
         |-> rsp_class_mask == BIT_COMM)
      else $error("communications class not reported alone");

   a_av_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_class_mask & (BIT_AUDIO | BIT_VIDEO)) != 32'd0
         |-> (rsp_class_mask & ~(BIT_AUDIO | BIT_VIDEO)) == 32'd0)
      else $error("audio/video mask carries other classes");

endmodule

bind usb_descriptor_class_mask_unit usbdcm_checker u_usbdcm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_class_mask (rsp_class_mask)
);

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for usb_descriptor_class_mask_unit. A cycle-free model
// of the descriptor walk and class mask follows every accepted word and
// queues the expected mask for each end-device word. Directed tests cover the
// corner cases of the walk, then random devices are built from well-formed
// configurations with truncated lengths, short, zero and one-byte
// descriptors mixed in, and stray noise words between them.
// ----------------------------------------------------------------------------
module tb;
   import usbdcm_pkg::*;

   localparam int RANDOM_WORDS   = 1550;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = OP_BEGIN_DEVICE;
   logic [7:0]  req_data_byte = 8'd0;
   logic [15:0] req_total_length = 16'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_class_mask;

   // walk model state
   logic [31:0] acc_mask = 32'd0;
   logic [15:0] cfg_total = 16'd0;
   logic [15:0] pos_cnt = 16'd0;
   logic [15:0] hdr_at = 16'd0;
   logic [7:0]  dlen = 8'd0;
   logic [7:0]  dtype = 8'd0;
   logic        walk_done = 1'b1;

   logic [31:0] mask_queue[$];
   logic [7:0]  desc_bytes[$];
   logic [7:0]  known_codes[10] = '{8'h01, 8'h02, 8'h0A, 8'hE0, 8'h03,
                                    8'h07, 8'h08, 8'h09, 8'h0E, 8'h10};
   int errors = 0;
   int words_sent = 0;
   int burst_left = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int idle_cycles = 0;

   usb_descriptor_class_mask_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_total_length (req_total_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_class_mask   (rsp_class_mask)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] code_to_bits(input logic [7:0] code);
      case (code)
         8'h01: return BIT_AUDIO;
         8'h02, 8'h0A, 8'hE0: return BIT_COMM;
         8'h03: return BIT_HID;
         8'h07: return BIT_PRINTER;
         8'h08: return BIT_STORAGE;
         8'h09: return BIT_HUB;
         8'h0E: return BIT_VIDEO;
         8'h10: return BIT_AUDIO | BIT_VIDEO;
         default: return BIT_OTHER;
      endcase
   endfunction

   function automatic logic [31:0] priority_reduce(input logic [31:0] m);
      if ((m & BIT_PRINTER) != 0) return BIT_PRINTER;
      if ((m & BIT_COMM) != 0) return BIT_COMM;
      if ((m & (BIT_AUDIO | BIT_VIDEO)) != 0) return m & (BIT_AUDIO | BIT_VIDEO);
      return m;
   endfunction

   task automatic take_length(input logic [7:0] b);
      if (17'(hdr_at) + 17'd2 > 17'(cfg_total)) begin
         walk_done = 1'b1;
      end else begin
         dlen = b;
      end
   endtask

   task automatic walk_one_byte(input logic [7:0] b);
      logic [15:0] rel;
      rel = pos_cnt - hdr_at;
      if (rel == 16'd0) begin
         take_length(b);
         return;
      end
      if (rel == 16'd1) begin
         dtype = b;
         if (dlen == 8'd0 || 17'(hdr_at) + 17'(dlen) > 17'(cfg_total)) begin
            walk_done = 1'b1;
            return;
         end
         // one-byte descriptor: its type byte doubles as the next length
         if (dlen == 8'd1) begin
            hdr_at = pos_cnt;
            take_length(b);
            return;
         end
      end
      if (rel == CLASS_OFFSET && dtype == INTF_TYPE && dlen >= INTF_MIN_LEN) begin
         acc_mask |= code_to_bits(b);
      end
      if (17'(rel) + 17'd1 == 17'(dlen)) begin
         hdr_at = pos_cnt + 16'd1;
      end
   endtask

   task automatic predict_class_mask(input op_type op, input logic [7:0] b,
                                     input logic [15:0] tl);
      case (op)
         OP_BEGIN_DEVICE: begin
            acc_mask = (b != 8'd0) ? code_to_bits(b) : 32'd0;
            walk_done = 1'b1;
         end
         OP_BEGIN_CONFIG: begin
            cfg_total = tl;
            pos_cnt = 16'd0;
            hdr_at = 16'd0;
            dlen = 8'd0;
            dtype = 8'd0;
            walk_done = 1'b0;
         end
         OP_DESC_BYTE: begin
            if (!walk_done) begin
               walk_one_byte(b);
               pos_cnt = pos_cnt + 16'd1;
            end
         end
         default: begin
            acc_mask = priority_reduce(acc_mask);
            walk_done = 1'b1;
            mask_queue.push_back(acc_mask);
         end
      endcase
   endtask

   // one word through the request channel, with burst and gap idling
   task automatic send_word(input op_type op, input logic [7:0] b, input logic [15:0] tl);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= b;
      req_total_length <= tl;
      do @(posedge clock); while (req_stall);
      words_sent++;
      predict_class_mask(op, b, tl);
   endtask

   task automatic send_bytes(input logic [7:0] bytes[$]);
      foreach (bytes[i]) send_word(OP_DESC_BYTE, bytes[i], 16'($urandom));
   endtask

   task automatic add_desc(input int len, input logic [7:0] kind, input logic [7:0] code);
      desc_bytes.push_back(8'(len));
      if (len != 1) desc_bytes.push_back(kind);
      for (int i = 2; i < len; i++) begin
         desc_bytes.push_back((i == 5) ? code : 8'($urandom_range(0, 255)));
      end
   endtask

   function automatic logic [7:0] pick_class();
      if ($urandom_range(0, 9) < 6) return known_codes[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_config();
      int slots;
      int pick;
      int size;
      logic [15:0] tl;
      desc_bytes.delete();
      add_desc(9, 8'h02, 8'h00);
      slots = $urandom_range(0, 4);
      for (int s = 0; s < slots; s++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) add_desc(9, INTF_TYPE, pick_class());
         else if (pick < 65) add_desc(7, 8'h05, 8'h00);
         else if (pick < 73) add_desc($urandom_range(2, 5), INTF_TYPE, pick_class());
         else if (pick < 80) add_desc(1, 8'h00, 8'h00);
         else if (pick < 85) add_desc(0, INTF_TYPE, 8'h00);
         else if (pick < 92) add_desc($urandom_range(6, 20), INTF_TYPE, pick_class());
         else add_desc($urandom_range(2, 15), 8'($urandom_range(0, 255)), pick_class());
      end
      size = desc_bytes.size();
      pick = $urandom_range(0, 9);
      if (pick < 7) tl = 16'(size);
      else if (pick == 7) tl = 16'($urandom_range(0, size));
      else if (pick == 8) tl = 16'(size + $urandom_range(1, 20));
      else tl = 16'($urandom_range(0, 65535));
      send_word(OP_BEGIN_CONFIG, 8'($urandom_range(0, 255)), tl);
      send_bytes(desc_bytes);
      // trailing bytes past the end of the configuration
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) send_word(OP_DESC_BYTE, 8'($urandom), 16'($urandom));
      end
   endtask

   task automatic send_device();
      logic [7:0] dev_class;
      dev_class = ($urandom_range(0, 9) < 3) ? 8'd0 : pick_class();
      send_word(OP_BEGIN_DEVICE, dev_class, 16'($urandom));
      repeat ($urandom_range(1, 2)) send_config();
      send_word(OP_END_DEVICE, 8'($urandom), 16'($urandom));
   endtask

   task automatic send_noise();
      int pick;
      op_type op;
      repeat ($urandom_range(3, 15)) begin
         pick = $urandom_range(0, 9);
         op = (pick < 6) ? OP_DESC_BYTE : op_type'($urandom_range(0, 3));
         send_word(op, 8'($urandom), 16'($urandom));
      end
   endtask

   // end of device with no begin, then again on the already reduced mask
   task automatic test_end_without_begin();
      send_word(OP_END_DEVICE, 8'hFF, 16'hFFFF);
      send_word(OP_END_DEVICE, 8'h00, 16'h0000);
   endtask

   task automatic test_device_class();
      send_word(OP_BEGIN_DEVICE, 8'h10, 16'h0000);
      send_word(OP_END_DEVICE, 8'h00, 16'h0000);
      send_word(OP_BEGIN_DEVICE, 8'hFF, 16'h0000);
      send_word(OP_END_DEVICE, 8'h00, 16'h0000);
   endtask

   task automatic test_interface_walk();
      send_word(OP_BEGIN_DEVICE, 8'h00, 16'h0000);
      send_word(OP_BEGIN_CONFIG, 8'hFF, 16'hFFFF);
      send_bytes('{8'h02, 8'h02, 8'h06, 8'h04, 8'hFF, 8'h00, 8'h00, 8'h07});
      send_word(OP_END_DEVICE, 8'h00, 16'h0000);
   endtask

   // zero length total, one-byte descriptor, short interface, zero bLength
   task automatic test_walk_repairs();
      send_word(OP_BEGIN_CONFIG, 8'h00, 16'h0000);
      send_word(OP_DESC_BYTE, 8'hFF, 16'h0000);
      send_word(OP_BEGIN_CONFIG, 8'h00, 16'd9);
      send_bytes('{8'h01, 8'h05, 8'h04, 8'h00, 8'h00, 8'h02, 8'h00, 8'h04, 8'h0E});
      send_word(OP_END_DEVICE, 8'h00, 16'h0000);
   endtask

   task automatic test_random_devices();
      int start_words;
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         else send_device();
      end
   endtask

   // result side stall pattern: quiet spells, sparse, solid runs, alternating
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = (stall_mode == 2) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= 1'b1;
         default: rsp_stall <= stall_left[0];
      endcase
   end

   always @(posedge clock) begin : check_masks
      logic [31:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mask_queue.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual class_mask %h",
                     $time, rsp_class_mask);
            errors++;
         end else begin
            want = mask_queue.pop_front();
            if (rsp_class_mask !== want) begin
               $display("%0t: class_mask mismatch, expected %h, actual %h",
                        $time, want, rsp_class_mask);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_end_without_begin();
      test_device_class();
      test_interface_walk();
      test_walk_repairs();
      test_random_devices();
      req_valid <= 1'b0;
      while (mask_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
